[rtl/dfmt_pkg.sv]
`default_nettype none

package dfmt_pkg;

    localparam int VALUE_W        = 32;
    localparam int COUNT_W        = 4;
    localparam int COL_W          = 8;
    localparam int PAGE_W         = 3;
    localparam int CODE_W         = 6;
    localparam int STEP_W         = 7;
    localparam int MAX_DIGITS_DEF = 10;

    localparam logic [STEP_W-1:0] STEP_RESET = 7'd8;
    localparam logic [CODE_W-1:0] CHR_BLANK  = 6'h20;
    localparam logic [CODE_W-1:0] CHR_ZERO   = 6'h30;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] digit_count;
        logic [COL_W-1:0]   start_col;
        logic [PAGE_W-1:0]  page;
    } in_item_t;

    typedef struct packed {
        logic [COL_W-1:0]  column;
        logic [PAGE_W-1:0] page_out;
        logic [CODE_W-1:0] char_code;
        logic              last;
    } out_item_t;

endpackage

`default_nettype wire

[rtl/dfmt_dabble.sv]
`default_nettype none

module dfmt_dabble
    import dfmt_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    load,
    input  wire logic [VALUE_W-1:0]      value,
    output logic                         done,
    output logic [4*MAX_DIGITS-1:0]      bcd
);

    localparam int BCD_W = 4 * MAX_DIGITS;
    localparam int CNT_W = $clog2(VALUE_W);

    logic [VALUE_W-1:0] shift_reg, shift_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [BCD_W-1:0]   adjusted;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               running_reg, running_next;
    logic               done_reg, done_next;

    // Add three to every digit of five or more before each shift.
    always_comb
    begin
        for (int d = 0; d < MAX_DIGITS; d++)
        begin
            if (bcd_reg[4*d +: 4] >= 4'd5)
                adjusted[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            else
                adjusted[4*d +: 4] = bcd_reg[4*d +: 4];
        end
    end

    always_comb
    begin
        shift_next   = shift_reg;
        bcd_next     = bcd_reg;
        cnt_next     = cnt_reg;
        running_next = running_reg;
        done_next    = 1'b0;
        if (load)
        begin
            shift_next   = value;
            bcd_next     = '0;
            cnt_next     = '0;
            running_next = 1'b1;
        end
        else if (running_reg)
        begin
            shift_next = {shift_reg[VALUE_W-2:0], 1'b0};
            if (BCD_W > 1)
                bcd_next = {adjusted[BCD_W-2:0], shift_reg[VALUE_W-1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(VALUE_W - 1))
            begin
                running_next = 1'b0;
                done_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            running_reg <= running_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        bcd_reg   <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

`default_nettype wire

[rtl/dfmt_emit.sv]
`default_nettype none

module dfmt_emit
    import dfmt_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    capture,
    input  wire logic [COUNT_W-1:0]      count,
    input  wire logic [COL_W-1:0]        start_col,
    input  wire logic [PAGE_W-1:0]       page,
    input  wire logic                    go,
    input  wire logic [4*MAX_DIGITS-1:0] bcd,
    input  wire logic [STEP_W-1:0]       char_step,
    output logic                         finishing,
    output logic                         strobe,
    output out_item_t                    result
);

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    logic [4*MAX_DIGITS-1:0] bcd_reg, bcd_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [COL_W-1:0]        col_reg, col_next;
    logic [PAGE_W-1:0]       page_reg, page_next;
    logic                    active_reg, active_next;
    logic                    shown_reg, shown_next;
    logic                    strobe_reg, strobe_next;
    out_item_t               result_reg, result_next;
    logic [3:0]              digit;
    logic                    final_pos;

    assign digit     = bcd_reg[4*idx_reg +: 4];
    assign final_pos = (idx_reg == '0);

    always_comb
    begin
        bcd_next    = bcd_reg;
        idx_next    = idx_reg;
        col_next    = col_reg;
        page_next   = page_reg;
        active_next = active_reg;
        shown_next  = shown_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        if (capture)
        begin
            idx_next   = IDX_W'(count - 1'b1);
            col_next   = start_col;
            page_next  = page;
            shown_next = 1'b0;
        end
        if (go)
        begin
            bcd_next    = bcd;
            active_next = 1'b1;
        end
        else if (active_reg)
        begin
            strobe_next          = 1'b1;
            result_next.column   = col_reg;
            result_next.page_out = page_reg;
            result_next.last     = final_pos;
            if (!shown_reg && !final_pos && digit == 4'd0)
                result_next.char_code = CHR_BLANK;
            else
            begin
                result_next.char_code = CHR_ZERO | CODE_W'(digit);
                shown_next            = 1'b1;
            end
            col_next = col_reg + COL_W'(char_step);
            if (final_pos)
                active_next = 1'b0;
            else
                idx_next = idx_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg    <= bcd_next;
        idx_reg    <= idx_next;
        col_reg    <= col_next;
        page_reg   <= page_next;
        shown_reg  <= shown_next;
        result_reg <= result_next;
    end

    assign finishing = active_reg && final_pos && !go;
    assign strobe    = strobe_reg;
    assign result    = result_reg;

endmodule

`default_nettype wire

[rtl/decimal_field_formatter.sv]
`default_nettype none

// Decimal field formatter.
// An item is taken at a rising edge with start high and busy low. The operand
// gives a 32-bit value, a digit count, a start column and a page. Counts above
// the configured maximum are saturated; a count of zero produces nothing.
// The value is converted bit-serially into packed decimal, one bit a cycle,
// followed by one result per digit position, most significant first, one each
// cycle. Busy stays high until the last result is being formed, and a new
// item is not taken before then.
// Each result is valid for the single cycle in which strobe is high and cannot
// be held off by the receiver. The character step register must be written
// through cfg_we and cfg_data while the block is idle; this is not enforced.
// Reset sets the character step to eight, clears busy and strobe, and drops
// any item in progress.

module decimal_field_formatter
    import dfmt_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire in_item_t          operand,
    output logic                   strobe,
    output out_item_t              result,
    input  wire logic              cfg_we,
    input  wire logic [STEP_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic [COUNT_W-1:0]      count_sat;
    logic                    accept;
    logic                    conv_done;
    logic                    finishing;
    logic [4*MAX_DIGITS-1:0] bcd;

    assign accept    = start && (state_reg == ST_IDLE);
    assign count_sat = (operand.digit_count > COUNT_W'(MAX_DIGITS))
                       ? COUNT_W'(MAX_DIGITS) : operand.digit_count;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && count_sat != '0)
                    state_next = ST_CONV;
            end
            ST_CONV:
            begin
                if (conv_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (finishing)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign step_next = cfg_we ? cfg_data : step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_RESET;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    dfmt_dabble #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (accept && count_sat != '0),
        .value (operand.value),
        .done  (conv_done),
        .bcd   (bcd)
    );

    dfmt_emit #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .capture   (accept),
        .count     (count_sat),
        .start_col (operand.start_col),
        .page      (operand.page),
        .go        (conv_done && state_reg == ST_CONV),
        .bcd       (bcd),
        .char_step (step_reg),
        .finishing (finishing),
        .strobe    (strobe),
        .result    (result)
    );

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire
